FILE: design/mbss_pkg.sv
// Package for the masked byte signature scan block.
// Holds field widths, register indexes and reset values; no dependencies.
`default_nettype none

package mbss_pkg;

   localparam int MAX_PATTERN_DEFAULT = 16;
   localparam int OFFSET_BITS_DEFAULT = 32;

   localparam int BYTE_W        = 8;
   localparam int PATTERN_BYTES = 16;
   localparam int ADDR_W        = 48;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_INDEX_W   = 3;
   localparam int CARE_W        = 16;
   localparam int PLEN_W        = 5;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [ADDR_W-1:0]      addr_type;
   typedef logic [BYTE_W-1:0]      byte_type;

   localparam csr_index_type CSR_PATTERN_LOW    = 3'd0;
   localparam csr_index_type CSR_PATTERN_HIGH   = 3'd1;
   localparam csr_index_type CSR_CARE_MASK      = 3'd2;
   localparam csr_index_type CSR_PATTERN_LENGTH = 3'd3;
   localparam csr_index_type CSR_REGION_BASE    = 3'd4;

   localparam logic [CARE_W-1:0] CARE_MASK_RESET      = '1;
   localparam logic [PLEN_W-1:0] PATTERN_LENGTH_RESET = 5'd1;

endpackage

`default_nettype wire

FILE: design/masked_byte_signature_scan_top.sv
// Masked byte signature scan, top level.
// Uses mbss_pkg for widths, register indexes and reset values.
//
// Usage: bytes of a region arrive on req_ (req_data_byte, req_region_last) in
// address order. The window of recent bytes is compared against a pattern of
// up to 16 bytes, each with a care bit (clear = wildcard). One response per
// region on rsp_: found with the start address of the first match, or not
// found with address 0 when the last byte passes without a match. Bytes after
// a match give no response. Registers are written on csr_ only while idle;
// the user must keep to this, the block does not enforce it. Pipeline: a
// request is registered, compared combinationally and the response registered.
// One byte per cycle is sustained unless a pending response is stalled.
// Reset: synchronous, active high; clears pipeline valids, byte count, match
// flag and loads register defaults (care mask all ones, length 1).
// Stall: when rsp_ready is low with a response pending, the response holds;
// one more request is taken into the input register, then req_ready drops.
`default_nettype none

module masked_byte_signature_scan_top #(
   parameter int MAX_PATTERN = mbss_pkg::MAX_PATTERN_DEFAULT,
   parameter int OFFSET_BITS = mbss_pkg::OFFSET_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [mbss_pkg::BYTE_W-1:0]           req_data_byte,
   input  wire logic                                  req_region_last,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_found,
   output logic [mbss_pkg::ADDR_W-1:0]                rsp_match_address,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [mbss_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [mbss_pkg::CSR_DATA_W-1:0]       csr_data
);
   import mbss_pkg::*;

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int CMP_W = (LEN_W > PLEN_W) ? LEN_W : PLEN_W;
   localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   // configuration
   logic [CSR_DATA_W-1:0] pattern_low_ff, pattern_high_ff;
   logic [CARE_W-1:0]     care_mask_ff;
   logic [PLEN_W-1:0]     pattern_length_ff;
   addr_type              region_base_ff;

   // input register
   logic     in_valid_ff, in_valid_in;
   byte_type in_byte_ff;
   logic     in_last_ff;

   // scan state
   byte_type               window_ff   [MAX_PATTERN];
   byte_type               window_next [MAX_PATTERN];
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic                   done_ff, done_in;

   // result register
   logic     rsp_valid_ff, rsp_valid_in;
   logic     rsp_found_ff, rsp_found_in;
   addr_type rsp_addr_ff, rsp_addr_in;

   logic                         advance, process, hit, produce;
   logic [CMP_W-1:0]             len_raw, len_eff, len_m1;
   logic [MAX_PATTERN-1:0]       byte_ok;
   logic [PATTERN_BYTES-1:0][BYTE_W-1:0] pattern_bytes;
   logic [OFFSET_BITS-1:0]       start_off;

   assign csr_ready = 1'b1;
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign process   = in_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         care_mask_ff      <= CARE_MASK_RESET;
         pattern_length_ff <= PATTERN_LENGTH_RESET;
         region_base_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PATTERN_LOW:    pattern_low_ff    <= csr_data;
            CSR_PATTERN_HIGH:   pattern_high_ff   <= csr_data;
            CSR_CARE_MASK:      care_mask_ff      <= csr_data[CARE_W-1:0];
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_data[PLEN_W-1:0];
            CSR_REGION_BASE:    region_base_ff    <= csr_data[ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   // effective pattern length, clamped to 1..MAX_PATTERN
   always_comb begin
      len_raw = CMP_W'(pattern_length_ff);
      if (len_raw == '0) begin
         len_eff = CMP_W'(1);
      end else if (len_raw > CMP_W'(MAX_PATTERN)) begin
         len_eff = CMP_W'(MAX_PATTERN);
      end else begin
         len_eff = len_raw;
      end
      len_m1 = len_eff - CMP_W'(1);
   end

   assign pattern_bytes = {pattern_high_ff, pattern_low_ff};

   always_comb begin
      window_next[0] = in_byte_ff;
      for (int i = 1; i < MAX_PATTERN; i++) begin
         window_next[i] = window_ff[i-1];
      end
   end

   // pattern byte j lines up with window entry len-1-j
   for (genvar gj = 0; gj < MAX_PATTERN; gj++) begin : g_cmp
      if (gj < PATTERN_BYTES) begin : g_care
         logic [CMP_W-1:0] pos;
         logic [IDX_W-1:0] tap;
         assign pos = len_m1 - CMP_W'(gj);
         assign tap = pos[IDX_W-1:0];
         assign byte_ok[gj] = (CMP_W'(gj) >= len_eff) || !care_mask_ff[gj] ||
                              (window_next[tap] == pattern_bytes[gj]);
      end else begin : g_wild
         assign byte_ok[gj] = 1'b1;
      end
   end

   assign hit = !done_ff && (offset_ff != '1) &&
                (offset_ff >= OFFSET_BITS'(len_m1)) && (&byte_ok);
   assign produce   = hit || (in_last_ff && !done_ff);
   assign start_off = offset_ff - OFFSET_BITS'(len_m1);

   always_comb begin
      in_valid_in  = in_valid_ff;
      offset_in    = offset_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_addr_in  = rsp_addr_ff;
      if (advance) begin
         in_valid_in  = 1'b0;
         rsp_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end
      if (process) begin
         rsp_valid_in = produce;
         rsp_found_in = hit;
         rsp_addr_in  = hit ? region_base_ff + ADDR_W'(start_off) : '0;
         if (in_last_ff) begin
            offset_in = '0;
            done_in   = 1'b0;
         end else begin
            offset_in = (offset_ff != '1) ? offset_ff + OFFSET_BITS'(1) : offset_ff;
            done_in   = done_ff || hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         offset_ff    <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         offset_ff    <= offset_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_region_last;
      end
      if (process) begin
         for (int i = 0; i < MAX_PATTERN; i++) begin
            window_ff[i] <= window_next[i];
         end
      end
      rsp_found_ff <= rsp_found_in;
      rsp_addr_ff  <= rsp_addr_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_match_address = rsp_addr_ff;

endmodule

`default_nettype wire

FILE: design/mbss_checker.sv
// Port-level checker for the masked byte signature scan top level.
// Standalone; attached to masked_byte_signature_scan_top by the bind below.
`default_nettype none

module mbss_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_found,
   input wire logic [47:0] rsp_match_address
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) &&
                                  $stable(rsp_match_address))
      else $error("stalled response changed");

   // not found carries address zero
   a_nf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_match_address == 48'd0)
      else $error("not-found response with nonzero address");

   // nothing pending after reset
   a_rst_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rst_req: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("request not ready after reset");

endmodule

bind masked_byte_signature_scan_top mbss_checker u_mbss_checker (.*);

`default_nettype wire

FILE: bench/masked_byte_signature_scan_top_tb.sv
// Testbench for masked_byte_signature_scan_top: directed and random byte regions
// checked against a scoreboard that predicts each response. Depends on mbss_pkg
// and the RTL of the top level.
`default_nettype none

module masked_byte_signature_scan_top_tb;
   import mbss_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int PHASE_ITEMS    = 150;
   localparam int RANDOM_PHASES  = 8;
   localparam int MAX_REGION     = 64;

   localparam csr_index_type CSR_SPARE_FIRST = 3'd5;
   localparam csr_index_type CSR_SPARE_LAST  = 3'd7;
   localparam addr_type      ADDR_TOP        = '1;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic     found;
      addr_type address;
   } scan_result_type;

   class scan_scoreboard;
      logic [CSR_DATA_W-1:0]          pattern_low;
      logic [CSR_DATA_W-1:0]          pattern_high;
      logic [CARE_W-1:0]              care_mask;
      logic [PLEN_W-1:0]              pattern_length;
      addr_type                       region_base;
      byte_type                       window [PATTERN_BYTES];
      logic [OFFSET_BITS_DEFAULT-1:0] offset;
      bit                             match_done;
      scan_result_type                expected_results [$];
      int                             errors;

      function new();
         pattern_low    = '0;
         pattern_high   = '0;
         care_mask      = CARE_MASK_RESET;
         pattern_length = PATTERN_LENGTH_RESET;
         region_base    = '0;
         errors         = 0;
         clear_region();
      endfunction

      function void clear_region();
         foreach (window[k]) window[k] = '0;
         offset     = '0;
         match_done = 1'b0;
      endfunction

      function int active_length();
         if (pattern_length == 0) return 1;
         if (pattern_length > PATTERN_BYTES) return PATTERN_BYTES;
         return int'(pattern_length);
      endfunction

      function byte_type pattern_byte(int j);
         logic [2*CSR_DATA_W-1:0] pattern;
         pattern = {pattern_high, pattern_low};
         return pattern[8*j +: 8];
      endfunction

      function bit window_matches(int len);
         for (int j = 0; j < len; j++) begin
            if (care_mask[j] && window[len-1-j] != pattern_byte(j)) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void write_register(csr_index_type index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_PATTERN_LOW:    pattern_low    = data;
            CSR_PATTERN_HIGH:   pattern_high   = data;
            CSR_CARE_MASK:      care_mask      = data[CARE_W-1:0];
            CSR_PATTERN_LENGTH: pattern_length = data[PLEN_W-1:0];
            CSR_REGION_BASE:    region_base    = data[ADDR_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(byte_type data, logic last);
         int              len;
         longint unsigned count;
         scan_result_type result;
         len = active_length();
         for (int k = PATTERN_BYTES - 1; k > 0; k--) window[k] = window[k-1];
         window[0] = data;
         if (!match_done && offset != '1) begin
            count = 64'(offset) + 64'd1;
            if (count >= 64'(len) && window_matches(len)) begin
               result.found   = 1'b1;
               result.address = region_base + addr_type'(count - 64'(len));
               expected_results.push_back(result);
               match_done = 1'b1;
            end
         end
         if (offset != '1) offset++;
         if (last) begin
            if (!match_done) begin
               result.found   = 1'b0;
               result.address = '0;
               expected_results.push_back(result);
            end
            clear_region();
         end
      endfunction

      task report_mismatch(string msg);
         $display("ERROR @%0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_response(logic found, addr_type address);
         scan_result_type want;
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected response found=%b addr=%h", found, address));
            return;
         end
         want = expected_results.pop_front();
         if (found !== want.found)
            report_mismatch($sformatf("found %b, want %b", found, want.found));
         if (address !== want.address)
            report_mismatch($sformatf("match_address %h, want %h", address, want.address));
      endtask

      function int outstanding();
         return expected_results.size();
      endfunction
   endclass

   logic                   clock           = 1'b0;
   logic                   reset           = 1'b1;
   logic                   req_valid       = 1'b0;
   logic                   req_ready;
   byte_type               req_data_byte   = '0;
   logic                   req_region_last = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready       = 1'b1;
   logic                   rsp_found;
   addr_type               rsp_match_address;
   logic                   csr_valid       = 1'b0;
   logic                   csr_ready;
   csr_index_type          csr_index       = CSR_PATTERN_LOW;
   logic [CSR_DATA_W-1:0]  csr_data        = '0;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int items_sent         = 0;
   int quiet_cycles       = 0;

   scan_scoreboard sb = new();

   masked_byte_signature_scan_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_region_last   (req_region_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_match_address (rsp_match_address),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_found, rsp_match_address);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
            || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic send_byte(byte_type data, logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_data_byte   <= data;
      req_region_last <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(data, last);
      items_sent++;
   endtask

   task automatic write_csr(csr_index_type index, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_register(index, data);
   endtask

   task automatic release_csr();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Hold off requests until every response is back, then let the pipe settle.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_idle(idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         IDLE_SENDER:   begin sender_idle_pct = 84; receiver_stall_pct = 0;  end
         IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 84; end
         default:       begin sender_idle_pct = 34; receiver_stall_pct = 34; end
      endcase
   endtask

   task automatic run_directed();
      logic [CSR_DATA_W-1:0] lo;
      logic [CSR_DATA_W-1:0] hi;
      lo = 64'h7766_5544_3322_11FF;
      hi = 64'hFFEE_DDCC_BBAA_9900;
      // defaults: one byte pattern 0x00; match on the last byte, then a miss
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'hAB, 1'b1);
      wait_idle();
      write_csr(CSR_PATTERN_LOW, lo);
      write_csr(CSR_PATTERN_HIGH, hi);
      write_csr(CSR_CARE_MASK, '1);
      write_csr(CSR_PATTERN_LENGTH, 64'd16);
      write_csr(CSR_REGION_BASE, {16'hFFFF, 48'hFFFF_FFFF_FFFE});
      write_csr(CSR_SPARE_FIRST, {$urandom, $urandom});
      write_csr(CSR_SPARE_LAST, {$urandom, $urandom});
      release_csr();
      // full-length match at offset 3, address wraps; trailing byte ignored
      send_byte(8'h5A, 1'b0);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h3C, 1'b0);
      for (int j = 0; j < PATTERN_BYTES; j++) send_byte(sb.pattern_byte(j), 1'b0);
      send_byte(8'hC3, 1'b1);
      // region shorter than the pattern
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h11, 1'b1);
      wait_idle();
   endtask

   task automatic set_phase_config(int phase);
      logic [CSR_DATA_W-1:0] lo;
      logic [CSR_DATA_W-1:0] hi;
      logic [CARE_W-1:0]     mask;
      logic [PLEN_W-1:0]     len;
      addr_type              base;
      lo   = {$urandom, $urandom};
      hi   = {$urandom, $urandom};
      mask = CARE_W'($urandom);
      len  = PLEN_W'($urandom_range(2, 15));
      base = addr_type'({$urandom, $urandom});
      case (phase)
         0: begin len = 5'd16; mask = '1; base = ADDR_TOP; lo = '1; hi = '1; end
         1: begin len = 5'd0; lo = '0; hi = '0; base = '0; end
         2: begin len = 5'd31; mask = '0; end
         3: len = 5'd1;
         4: len = 5'd17;
         default: if ($urandom_range(1) == 0) mask = '1;
      endcase
      write_csr(CSR_PATTERN_LOW, lo);
      write_csr(CSR_PATTERN_HIGH, hi);
      write_csr(CSR_CARE_MASK, {$urandom, 16'($urandom), mask});
      write_csr(CSR_PATTERN_LENGTH, {$urandom, 27'($urandom), len});
      write_csr(CSR_REGION_BASE, {16'($urandom), base});
      release_csr();
   endtask

   // Mostly regions with the pattern planted at a random place, some with a
   // corrupted byte, the rest plain noise.
   task automatic run_regions(int target);
      int       first;
      int       len;
      int       size;
      int       start;
      int       kind;
      int       j;
      byte_type region_data [MAX_REGION];
      first = items_sent;
      while (items_sent - first < target) begin
         len = sb.active_length();
         case ($urandom_range(9))
            0:       size = $urandom_range(1, (len > 1) ? len - 1 : 1);
            1:       size = $urandom_range(32, MAX_REGION);
            default: size = $urandom_range(len, len + 12);
         endcase
         for (int k = 0; k < size; k++) region_data[k] = byte_type'($urandom);
         kind = $urandom_range(9);
         if (kind < 8 && size >= len) begin
            start = $urandom_range(size - len);
            for (j = 0; j < len; j++) begin
               if (sb.care_mask[j]) region_data[start+j] = sb.pattern_byte(j);
            end
            if (kind >= 6) begin
               j = $urandom_range(len - 1);
               region_data[start+j] ^= byte_type'($urandom_range(1, 255));
            end
         end
         for (int k = 0; k < size; k++) send_byte(region_data[k], k == size - 1);
         if ($urandom_range(14) == 0) wait_idle();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_idle(idle_mode_type'(p % 4));
         set_phase_config(p);
         run_regions(PHASE_ITEMS);
         wait_idle();
      end
      if (sb.outstanding() != 0) sb.report_mismatch("expected responses left over");
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
